[src/csl_pkg.sv]
// Shared types and constants for the compacting set list.
package csl_pkg;

	localparam int DEPTH = 16;
	localparam int KEY_W = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY
	} state_t;

	// Broadcast controls from the sequencer to every cell.
	typedef struct packed {
		logic cmp_en;
		logic rmv_en;
		logic app_en;
	} cell_ctrl_t;

endpackage

[src/csl_cell.sv]
// One list slot: holds a key, compares it and shifts from its upper neighbor.
module csl_cell
	import csl_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [KEY_W-1:0] key,
	input  logic             active,
	input  logic             app_sel,
	input  logic             found_in,
	input  logic [KEY_W-1:0] next_entry,
	output logic [KEY_W-1:0] entry,
	output logic             found_out
);

	logic [KEY_W-1:0] entry_q;
	logic             match_q;

	// A match here or in any lower slot moves this slot down.
	assign found_out = found_in | match_q;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			match_q <= active && (entry_q == key);
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctrl.app_en && app_sel) begin
			entry_q <= key;
		end else if (ctrl.rmv_en && found_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

[src/compacting_set_list_top.sv]
// Compacting set list: sequencer, entry count and a row of key cells.
// A request passes through the compare and apply states; its result is then registered.
// A new request is taken only in idle, after the previous one has been applied through the cell row;
// the apply step holds while the output register still waits.
// Reset clears the count and the control state; stored keys are undefined until written.
module compacting_set_list_top
	import csl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [1:0]             opcode,
	input  logic [31:0]            key,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic                   hit,
	output logic                   full_reject,
	output logic [COUNT_OUT_W-1:0] entry_count
);

	state_t state_q, state_d;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q;

	logic                   rsp_valid_q;
	logic                   hit_q;
	logic                   full_reject_q;
	logic [COUNT_OUT_W-1:0] entry_count_q;

	cell_ctrl_t       ctrl;
	logic             req_take;
	logic             apply_fire;
	logic             is_full;
	logic             any_found;
	logic [KEY_W-1:0] entry_w [DEPTH];
	logic             found_w [DEPTH+1];
	logic [CNT_W-1:0] count_next;
	logic             hit_next;
	logic             reject_next;

	assign req_take = req_valid && !req_stall;
	assign is_full  = (count_q == CNT_W'(DEPTH));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (req_valid) state_d = ST_CMP;
			ST_CMP:   state_d = ST_APPLY;
			ST_APPLY: if (!(rsp_valid_q && rsp_stall)) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req_stall   = 1'b1;
		apply_fire  = 1'b0;
		ctrl.cmp_en = 1'b0;
		ctrl.rmv_en = 1'b0;
		ctrl.app_en = 1'b0;
		unique case (state_q)
			ST_IDLE:  req_stall = 1'b0;
			ST_CMP:   ctrl.cmp_en = 1'b1;
			ST_APPLY: begin
				apply_fire  = !(rsp_valid_q && rsp_stall);
				ctrl.rmv_en = apply_fire && (op_q == OP_REMOVE);
				ctrl.app_en = apply_fire && (op_q == OP_APPEND) && !is_full;
			end
			default: req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q  <= op_t'(opcode);
			key_q <= key[KEY_W-1:0];
		end
	end

	// Cell row; the found flag ripples up from slot zero.
	assign found_w[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = entry_w[i];
		end else begin : g_mid
			assign nxt = entry_w[i+1];
		end

		csl_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.key        (key_q),
			.active     (CNT_W'(i) < count_q),
			.app_sel    (CNT_W'(i) == count_q),
			.found_in   (found_w[i]),
			.next_entry (nxt),
			.entry      (entry_w[i]),
			.found_out  (found_w[i+1])
		);
	end

	assign any_found = found_w[DEPTH];

	always_comb begin
		count_next  = count_q;
		hit_next    = 1'b0;
		reject_next = 1'b0;
		unique case (op_q)
			OP_APPEND: begin
				if (is_full) begin
					reject_next = 1'b1;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				hit_next = any_found;
				if (any_found) begin
					count_next = count_q - CNT_W'(1);
				end
			end
			OP_QUERY: hit_next = any_found;
			OP_NONE:  hit_next = 1'b0;
			default:  hit_next = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (apply_fire) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result beat until it is taken.
	always_ff @(posedge clk) begin
		if (apply_fire) begin
			hit_q         <= hit_next;
			full_reject_q <= reject_next;
			entry_count_q <= COUNT_OUT_W'(count_next);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign full_reject = full_reject_q;
	assign entry_count = entry_count_q;

endmodule
